### hw/rtl/bht_pkg.sv
`timescale 1ns / 1ps
// Package for the byte histogram block: opcodes, field widths and the scan status struct.
// No dependencies.
package bht_pkg;

  localparam int BYTE_W     = 8;
  localparam int NUM_BYTES  = 256;
  localparam int OUT_CNT_W  = 32;
  localparam int DIST_W     = 9;

  localparam logic OP_COUNT   = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;
  localparam logic [BYTE_W-1:0] LAST_IDX  = 8'hFF;

  typedef struct packed {
    logic              active;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              done;
    logic              found;
    logic [BYTE_W-1:0] best_byte;
  } scan_st_t;

endpackage

### hw/rtl/bht_mem.sv
`timescale 1ns / 1ps
// Count memory: 256 counters, one write port and one read port with registered read data.
// Depends on bht_pkg.
module bht_mem #(
  parameter int CW = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [bht_pkg::BYTE_W-1:0] wr_addr,
  input  logic [CW-1:0]              wr_data,
  input  logic                       rd_en,
  input  logic [bht_pkg::BYTE_W-1:0] rd_addr,
  output logic [CW-1:0]              rd_data
);

  logic [CW-1:0] mem [bht_pkg::NUM_BYTES];
  logic [CW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/bht_scan.sv
`timescale 1ns / 1ps
// Extract sequencer: walks all counters in signed byte order and keeps the leader.
// Depends on bht_pkg; reads the count memory through the top level.
module bht_scan #(
  parameter int CW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [bht_pkg::NUM_BYTES-1:0] seen,
  input  logic [CW-1:0]                 rd_data,
  output bht_pkg::scan_st_t             st,
  output logic [CW-1:0]                 best_cnt
);

  logic                        run_r, run_nxt;
  logic [bht_pkg::BYTE_W-1:0]  idx_r, idx_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic                        cmp_last_r, cmp_last_nxt;
  logic [bht_pkg::BYTE_W-1:0]  cmp_addr_r;
  logic                        done_r, done_nxt;
  logic                        found_r, found_nxt;
  logic [bht_pkg::BYTE_W-1:0]  best_byte_r, best_byte_nxt;
  logic [CW-1:0]               best_cnt_r, best_cnt_nxt;
  logic [bht_pkg::BYTE_W-1:0]  rd_addr;
  logic                        take;

  assign rd_addr = idx_r ^ bht_pkg::SIGN_FLIP;
  assign take    = cmp_vld_r && seen[cmp_addr_r] && (!found_r || (rd_data > best_cnt_r));

  always_comb begin
    run_nxt       = run_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_last_nxt  = 1'b0;
    done_nxt      = 1'b0;
    found_nxt     = found_r;
    best_byte_nxt = best_byte_r;
    best_cnt_nxt  = best_cnt_r;
    if (go) begin
      run_nxt       = 1'b1;
      idx_nxt       = '0;
      found_nxt     = 1'b0;
      best_byte_nxt = '0;
      best_cnt_nxt  = '0;
    end else if (run_r) begin
      cmp_vld_nxt  = 1'b1;
      cmp_last_nxt = (idx_r == bht_pkg::LAST_IDX);
      idx_nxt      = idx_r + 1'b1;
      if (idx_r == bht_pkg::LAST_IDX) begin
        run_nxt = 1'b0;
      end
    end
    if (take) begin
      found_nxt     = 1'b1;
      best_byte_nxt = cmp_addr_r;
      best_cnt_nxt  = rd_data;
    end
    if (cmp_vld_r && cmp_last_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      idx_r      <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      done_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      run_r      <= run_nxt;
      idx_r      <= idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      cmp_last_r <= cmp_last_nxt;
      done_r     <= done_nxt;
      found_r    <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr_r  <= rd_addr;
    best_byte_r <= best_byte_nxt;
    best_cnt_r  <= best_cnt_nxt;
  end

  assign st.active    = run_r | cmp_vld_r | done_r;
  assign st.rd_en     = run_r;
  assign st.rd_addr   = rd_addr;
  assign st.done      = done_r;
  assign st.found     = found_r;
  assign st.best_byte = best_byte_r;
  assign best_cnt     = best_cnt_r;

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_vld_r && cmp_last_r) |=> done_r) else $error("scan did not finish after last entry");
  a_run_excl_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && done_r)) else $error("scan reading while reporting");
  a_found_has_seen: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (found_r == (seen != '0))) else $error("found flag disagrees with seen set");

endmodule

### hw/rtl/byte_histogram_top_extract_core.sv
`timescale 1ns / 1ps
// Top level of the byte histogram: count pipeline, seen flags and extract result.
// Depends on bht_pkg, bht_mem and bht_scan.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+--------------------------
//  request  | in_opcode, in_data_byte                            | start high, busy low
//  result   | out_leader_byte, out_leader_count, out_empty_res,  | out_valid, one cycle,
//           | out_distinct_count                                 | cannot be held off
//
// A count request is taken every cycle while busy is low; its read-modify-write writes the
// increment from the s2 stage, with forwarding from the previous write. An extract request
// holds busy during the walk over the 256 counters through the single memory read port,
// and the result appears in the last busy cycle. Reset clears the seen flags, which also
// mark counters valid, so no clearing pass is needed. The receiver cannot stall.
module byte_histogram_top_extract_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [bht_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                          out_valid,
  output logic [bht_pkg::BYTE_W-1:0]    out_leader_byte,
  output logic [bht_pkg::OUT_CNT_W-1:0] out_leader_count,
  output logic                          out_empty_res,
  output logic [bht_pkg::DIST_W-1:0]    out_distinct_count
);

  logic                          accept;
  logic                          cnt_go;
  logic                          ext_go;
  logic                          s2_vld_r;
  logic [bht_pkg::BYTE_W-1:0]    s2_addr_r;
  logic                          fwd_vld_r;
  logic [bht_pkg::BYTE_W-1:0]    fwd_addr_r;
  logic [COUNT_WIDTH-1:0]        fwd_data_r;
  logic [bht_pkg::NUM_BYTES-1:0] seen_r, seen_nxt;
  logic [bht_pkg::DIST_W-1:0]    distinct_r, distinct_nxt;
  logic [COUNT_WIDTH-1:0]        cur_cnt;
  logic [COUNT_WIDTH-1:0]        inc_cnt;
  logic                          wr_en;
  logic [bht_pkg::BYTE_W-1:0]    wr_addr;
  logic [COUNT_WIDTH-1:0]        wr_data;
  logic                          rd_en;
  logic [bht_pkg::BYTE_W-1:0]    rd_addr;
  logic [COUNT_WIDTH-1:0]        rd_data;
  logic [COUNT_WIDTH-1:0]        best_cnt;
  logic                          zero_wr;
  logic [bht_pkg::OUT_CNT_W-1:0] clamp_cnt;
  bht_pkg::scan_st_t             scan_st;

  assign busy   = scan_st.active;
  assign accept = start && !busy;
  assign cnt_go = accept && (in_opcode == bht_pkg::OP_COUNT);
  assign ext_go = accept && (in_opcode == bht_pkg::OP_EXTRACT);

  assign cur_cnt = (fwd_vld_r && (fwd_addr_r == s2_addr_r)) ? fwd_data_r :
                   (seen_r[s2_addr_r] ? rd_data : '0);
  assign inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

  assign zero_wr = scan_st.done && scan_st.found;
  assign wr_en   = s2_vld_r || zero_wr;
  assign wr_addr = s2_vld_r ? s2_addr_r : scan_st.best_byte;
  assign wr_data = s2_vld_r ? inc_cnt : '0;

  assign rd_en   = cnt_go || scan_st.rd_en;
  assign rd_addr = scan_st.rd_en ? scan_st.rd_addr : in_data_byte;

  always_comb begin
    seen_nxt     = seen_r;
    distinct_nxt = distinct_r;
    if (s2_vld_r && !seen_r[s2_addr_r]) begin
      seen_nxt[s2_addr_r] = 1'b1;
      distinct_nxt        = distinct_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      seen_r     <= '0;
      distinct_r <= '0;
    end else begin
      s2_vld_r   <= cnt_go;
      fwd_vld_r  <= wr_en;
      seen_r     <= seen_nxt;
      distinct_r <= distinct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r  <= in_data_byte;
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
  end

  bht_mem #(.CW(COUNT_WIDTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bht_scan #(.CW(COUNT_WIDTH)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ext_go),
    .seen     (seen_r),
    .rd_data  (rd_data),
    .st       (scan_st),
    .best_cnt (best_cnt)
  );

  generate
    if (COUNT_WIDTH > bht_pkg::OUT_CNT_W) begin : g_clamp
      assign clamp_cnt = (|best_cnt[COUNT_WIDTH-1:bht_pkg::OUT_CNT_W]) ? '1 :
                         best_cnt[bht_pkg::OUT_CNT_W-1:0];
    end else begin : g_ext
      assign clamp_cnt = bht_pkg::OUT_CNT_W'(best_cnt);
    end
  endgenerate

  assign out_valid          = scan_st.done;
  assign out_empty_res      = !scan_st.found;
  assign out_leader_byte    = scan_st.found ? scan_st.best_byte : '0;
  assign out_leader_count   = scan_st.found ? clamp_cnt : '0;
  assign out_distinct_count = distinct_r;

  a_out_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");
  a_distinct_range: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= 9'd256) else $error("distinct count out of range");
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_vld_r && zero_wr)) else $error("count write collides with extract clear");
  a_distinct_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (distinct_r == '0))) else $error("empty flag mismatch");

endmodule

### test/byte_histogram_checker.sv
`timescale 1ns / 1ps
// Checker for the byte histogram block: watches the request and result ports,
// keeps its own histogram to predict each extract result and compares it. Depends on bht_pkg.
module byte_histogram_checker #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_opcode,
  input  logic [bht_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          out_valid,
  input  logic [bht_pkg::BYTE_W-1:0]    out_leader_byte,
  input  logic [bht_pkg::OUT_CNT_W-1:0] out_leader_count,
  input  logic                          out_empty_res,
  input  logic [bht_pkg::DIST_W-1:0]    out_distinct_count,
  output int                            fail_count,
  output int                            open_count
);
  import bht_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]    lead;
    logic [OUT_CNT_W-1:0] cnt;
    logic                 empty;
    logic [DIST_W-1:0]    distinct;
  } leader_rec_t;

  leader_rec_t            leader_q[$];
  logic [COUNT_WIDTH-1:0] hist_cnt [NUM_BYTES];
  logic                   hist_seen [NUM_BYTES];
  logic [DIST_W-1:0]      hist_distinct;
  int                     n_fail = 0;
  int                     n_open = 0;

  assign fail_count = n_fail;
  assign open_count = n_open;

  task automatic clear_histogram();
    for (int i = 0; i < NUM_BYTES; i++) begin
      hist_cnt[i]  = '0;
      hist_seen[i] = 1'b0;
    end
    hist_distinct = '0;
    leader_q.delete();
  endtask

  task automatic tally_byte(input logic [BYTE_W-1:0] b);
    if (hist_cnt[b] != {COUNT_WIDTH{1'b1}}) begin
      hist_cnt[b] = hist_cnt[b] + 1'b1;
    end
    if (!hist_seen[b]) begin
      hist_seen[b]  = 1'b1;
      hist_distinct = hist_distinct + 1'b1;
    end
  endtask

  // The walk runs in ascending signed order, so a strict compare keeps the
  // smallest signed byte on ties.
  task automatic take_leader();
    leader_rec_t       r;
    logic              found;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] best;
    logic [63:0]       best_cnt;
    found    = 1'b0;
    best     = '0;
    best_cnt = '0;
    for (int k = 0; k < NUM_BYTES; k++) begin
      v = BYTE_W'(k) ^ SIGN_FLIP;
      if (hist_seen[v] && (!found || 64'(hist_cnt[v]) > best_cnt)) begin
        found    = 1'b1;
        best     = v;
        best_cnt = 64'(hist_cnt[v]);
      end
    end
    r.lead     = best;
    r.cnt      = (best_cnt > 64'hFFFF_FFFF) ? '1 : best_cnt[OUT_CNT_W-1:0];
    r.empty    = !found;
    r.distinct = hist_distinct;
    if (found) begin
      hist_cnt[best] = '0;
    end
    leader_q.insert(leader_q.size(), r);
  endtask

  always @(posedge clk) begin : watch
    leader_rec_t exp_r;
    if (!rst_n) begin
      clear_histogram();
      n_open <= 0;
    end else begin
      if (start && !busy) begin
        if (in_opcode == OP_EXTRACT) begin
          take_leader();
        end else begin
          tally_byte(in_data_byte);
        end
      end
      if (out_valid) begin
        if (leader_q.size() == 0) begin
          if (n_fail < 10) begin
            $display("%0t: result without a pending extract:", $realtime);
            $display("%0t:           actual   byte=%02h cnt=%0d empty=%0b distinct=%0d",
                     $realtime, out_leader_byte, out_leader_count, out_empty_res,
                     out_distinct_count);
          end
          n_fail++;
        end else begin
          exp_r = leader_q.pop_front();
          if (exp_r.lead !== out_leader_byte || exp_r.cnt !== out_leader_count ||
              exp_r.empty !== out_empty_res || exp_r.distinct !== out_distinct_count) begin
            if (n_fail < 10) begin
              $display("%0t: mismatch: expected byte=%02h cnt=%0d empty=%0b distinct=%0d",
                       $realtime, exp_r.lead, exp_r.cnt, exp_r.empty, exp_r.distinct);
              $display("%0t:           actual   byte=%02h cnt=%0d empty=%0b distinct=%0d",
                       $realtime, out_leader_byte, out_leader_count, out_empty_res,
                       out_distinct_count);
            end
            n_fail++;
          end
        end
      end
      n_open <= leader_q.size();
    end
  end

endmodule

### test/tb_byte_histogram_top_extract_core.sv
`timescale 1ns / 1ps
// Testbench top for the byte histogram block: clock, reset, request stimulus and verdict.
// Depends on bht_pkg, byte_histogram_top_extract_core and byte_histogram_checker.
module tb_byte_histogram_top_extract_core;
  import bht_pkg::*;

  localparam int CW = 32;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_opcode = OP_COUNT;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_leader_byte;
  logic [OUT_CNT_W-1:0]  out_leader_count;
  logic                  out_empty_res;
  logic [DIST_W-1:0]     out_distinct_count;
  int                    fail_count;
  int                    open_count;
  logic                  gaps_on = 1'b1;
  logic [BYTE_W-1:0]     hot_bytes [6];
  logic [BYTE_W-1:0]     sweep [NUM_BYTES];

  always #5 clk = ~clk;

  byte_histogram_top_extract_core #(.COUNT_WIDTH(CW)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_leader_byte    (out_leader_byte),
    .out_leader_count   (out_leader_count),
    .out_empty_res      (out_empty_res),
    .out_distinct_count (out_distinct_count)
  );

  byte_histogram_checker #(.COUNT_WIDTH(CW)) u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_leader_byte    (out_leader_byte),
    .out_leader_count   (out_leader_count),
    .out_empty_res      (out_empty_res),
    .out_distinct_count (out_distinct_count),
    .fail_count         (fail_count),
    .open_count         (open_count)
  );

  task automatic issue(input logic op, input logic [BYTE_W-1:0] b);
    start        <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= b;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pause($urandom_range(1, 16));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (open_count != 0);
  endtask

  task automatic random_request(input int ext_odds);
    logic              op;
    logic [BYTE_W-1:0] b;
    op = ($urandom_range(1, ext_odds) == 1) ? OP_EXTRACT : OP_COUNT;
    b  = $urandom_range(0, 1) ? hot_bytes[$urandom_range(0, 5)] : BYTE_W'($urandom_range(0, 255));
    issue(op, b);
    maybe_gap();
  endtask

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int               j;
    logic [BYTE_W-1:0] tmp;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty store, signed tie order, all-zero leader, repeated byte.
    issue(OP_EXTRACT, 8'h00);
    issue(OP_EXTRACT, 8'hFF);
    issue(OP_COUNT, 8'h80);
    issue(OP_COUNT, 8'h7F);
    issue(OP_COUNT, 8'h00);
    issue(OP_COUNT, 8'hFF);
    repeat (5) issue(OP_EXTRACT, 8'h00);
    issue(OP_COUNT, 8'h55);
    issue(OP_COUNT, 8'h55);
    issue(OP_COUNT, 8'hAA);
    pause(3);
    issue(OP_COUNT, 8'h55);
    issue(OP_EXTRACT, 8'hAA);
    drain();

    foreach (hot_bytes[i]) hot_bytes[i] = BYTE_W'($urandom_range(0, 255));
    repeat (100) random_request(8);
    drain();

    // Every byte value counted once, in shuffled order, so the distinct count reaches 256.
    foreach (sweep[i]) sweep[i] = BYTE_W'(i);
    for (int i = NUM_BYTES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = sweep[i];
      sweep[i] = sweep[j];
      sweep[j] = tmp;
    end
    foreach (sweep[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        issue(OP_EXTRACT, BYTE_W'($urandom_range(0, 255)));
      end
      issue(OP_COUNT, sweep[i]);
      maybe_gap();
    end

    gaps_on = 1'b0;
    foreach (hot_bytes[i]) hot_bytes[i] = BYTE_W'($urandom_range(0, 255));
    repeat (60) random_request(6);
    issue(OP_EXTRACT, 8'h00);

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bht_pkg.sv
hw/rtl/bht_mem.sv
hw/rtl/bht_scan.sv
hw/rtl/byte_histogram_top_extract_core.sv
test/byte_histogram_checker.sv
test/tb_byte_histogram_top_extract_core.sv
